// ===== hw/rtl/six_axis_puck_report_parser_defines.svh =====
// ----------------------------------------------------------------------------
// six-axis puck report parser: assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_PUCK_REPORT_PARSER_DEFINES_SVH
`define SIX_AXIS_PUCK_REPORT_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SAPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sapp check failed");

// next-cycle implication, disabled in reset
`define SAPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sapp check failed");

`endif

// ===== hw/rtl/sapp_pkg.sv =====
// ----------------------------------------------------------------------------
// sapp_pkg
// types, codes and helpers shared by the puck report parser modules
// ----------------------------------------------------------------------------
package sapp_pkg;

   // axis count default
   localparam int NUM_AXES_DEF = 6;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int EVENT_W  = 3;
   localparam int INDEX_W  = 3;
   localparam int VALUE_W  = 16;
   localparam int BTN_W    = 9;
   localparam int DZ_W     = 4;
   localparam int LEN_W    = 5;
   localparam int RSP_TDATA_W = INDEX_W + VALUE_W + BTN_W + DZ_W;

   // report buffer: data nibbles between letter and terminator
   localparam int REPORT_MAX = 26;
   localparam int NIB_DEPTH  = REPORT_MAX - 2;
   localparam int AXIS_NIBS  = VALUE_W / NIB_W;

   localparam logic [DZ_W-1:0]    DZ_RESET   = 4'd8;
   localparam logic [VALUE_W-1:0] AXIS_OFFSET = 16'h8000;

   // event codes
   localparam logic [EVENT_W-1:0] EV_AXIS    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_BUTTONS = 3'd1;
   localparam logic [EVENT_W-1:0] EV_OTHER   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_NO_TERM = 3'd3;
   localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd4;
   localparam logic [EVENT_W-1:0] EV_MOUSE   = 3'd5;

   // input kinds
   localparam logic MODE_BYTE       = 1'b0;
   localparam logic MODE_RESET_DONE = 1'b1;

   // characters
   localparam logic [BYTE_W-1:0] CH_K  = 8'h6B;
   localparam logic [BYTE_W-1:0] CH_B  = 8'h62;
   localparam logic [BYTE_W-1:0] CH_M  = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_D  = 8'h64;
   localparam logic [BYTE_W-1:0] CH_N  = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_Q  = 8'h71;
   localparam logic [BYTE_W-1:0] CH_Z  = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_P  = 8'h70;
   localparam logic [BYTE_W-1:0] CH_C  = 8'h63;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   // controller to datapath commands
   typedef struct packed {
      logic                 shift_in;
      logic                 axis_shift;
      logic                 load_radius_cfg;
      logic                 load_radius_rpt;
      logic                 out_load;
      logic [EVENT_W-1:0]   out_event;
      logic                 out_axis;
      logic                 out_buttons;
      logic                 out_last;
      logic [INDEX_W-1:0]   axis_index;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
      logic mouse_bit;
   } sts_type;

   // report length per command letter, zero for unknown
   function automatic logic [LEN_W-1:0] length_for(input logic [BYTE_W-1:0] c);
      logic [LEN_W-1:0] len;
      unique case (c)
         CH_K:    len = 5'd5;
         CH_B:    len = 5'd2;
         CH_M:    len = 5'd3;
         CH_D:    len = 5'd26;
         CH_N:    len = 5'd3;
         CH_Q:    len = 5'd4;
         CH_Z:    len = 5'd2;
         CH_P:    len = 5'd4;
         CH_C:    len = 5'd4;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== hw/rtl/sapp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapp_ctrl
// protocol phase tracking, report framing and result sequencing
// ----------------------------------------------------------------------------
module sapp_ctrl #(
   parameter int NUM_AXES = sapp_pkg::NUM_AXES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   input  logic [sapp_pkg::BYTE_W-1:0]   req_tdata,
   input  sapp_pkg::sts_type             sts,
   output sapp_pkg::cmd_type             cmd
);

   // controller states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_AXIS = 1'b1;

   // protocol phases
   localparam logic [1:0] PH_RESETTING = 2'd0;
   localparam logic [1:0] PH_SYNCING   = 2'd1;
   localparam logic [1:0] PH_READING   = 2'd2;

   localparam logic [sapp_pkg::INDEX_W-1:0] AXIS_LAST = sapp_pkg::INDEX_W'(NUM_AXES - 1);

   logic                          state_ff, state_in;
   logic [1:0]                    phase_ff, phase_in;
   logic [sapp_pkg::LEN_W-1:0]    count_ff, count_in;
   logic [sapp_pkg::LEN_W-1:0]    exp_len_ff, exp_len_in;
   logic [sapp_pkg::BYTE_W-1:0]   letter_ff, letter_in;
   logic [sapp_pkg::INDEX_W-1:0]  axis_ff, axis_in;

   logic                          accept;
   logic [sapp_pkg::LEN_W-1:0]    len;
   logic [sapp_pkg::LEN_W-1:0]    count_next;

   assign req_tready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;
   assign len        = sapp_pkg::length_for(req_tdata);
   assign count_next = count_ff + 5'd1;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      exp_len_in = exp_len_ff;
      letter_in  = letter_ff;
      axis_in    = axis_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == sapp_pkg::MODE_RESET_DONE) begin
                  cmd.load_radius_cfg = 1'b1;
                  phase_in = PH_SYNCING;
                  count_in = '0;
               end else begin
                  unique case (phase_ff)
                     PH_SYNCING: begin
                        if (len == '0) begin
                           phase_in      = PH_RESETTING;
                           cmd.out_load  = 1'b1;
                           cmd.out_event = sapp_pkg::EV_UNKNOWN;
                           cmd.out_last  = 1'b1;
                        end else begin
                           letter_in  = req_tdata;
                           count_in   = 5'd1;
                           exp_len_in = len;
                           phase_in   = PH_READING;
                        end
                     end
                     PH_READING: begin
                        if (count_next < exp_len_ff) begin
                           cmd.shift_in = 1'b1;
                           count_in     = count_next;
                        end else begin
                           phase_in = PH_SYNCING;
                           count_in = '0;
                           if (req_tdata != sapp_pkg::CH_CR) begin
                              cmd.out_load  = 1'b1;
                              cmd.out_event = sapp_pkg::EV_NO_TERM;
                              cmd.out_last  = 1'b1;
                           end else begin
                              unique case (letter_ff)
                                 sapp_pkg::CH_K: begin
                                    cmd.out_load    = 1'b1;
                                    cmd.out_event   = sapp_pkg::EV_BUTTONS;
                                    cmd.out_buttons = 1'b1;
                                    cmd.out_last    = 1'b1;
                                 end
                                 sapp_pkg::CH_M: begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_last = 1'b1;
                                    if (sts.mouse_bit) begin
                                       cmd.out_event = sapp_pkg::EV_MOUSE;
                                       phase_in      = PH_RESETTING;
                                    end else begin
                                       cmd.out_event = sapp_pkg::EV_OTHER;
                                    end
                                 end
                                 sapp_pkg::CH_D: begin
                                    state_in = ST_AXIS;
                                    axis_in  = '0;
                                 end
                                 sapp_pkg::CH_N: begin
                                    cmd.load_radius_rpt = 1'b1;
                                    cmd.out_load        = 1'b1;
                                    cmd.out_event       = sapp_pkg::EV_OTHER;
                                    cmd.out_last        = 1'b1;
                                 end
                                 default: begin
                                    cmd.out_load  = 1'b1;
                                    cmd.out_event = sapp_pkg::EV_OTHER;
                                    cmd.out_last  = 1'b1;
                                 end
                              endcase
                           end
                        end
                     end
                     default: begin
                        // bytes are dropped while the device is resetting
                     end
                  endcase
               end
            end
         end
         ST_AXIS: begin
            // one axis word per free output slot
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_event  = sapp_pkg::EV_AXIS;
               cmd.out_axis   = 1'b1;
               cmd.axis_index = axis_ff;
               cmd.axis_shift = 1'b1;
               if (axis_ff == AXIS_LAST) begin
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  axis_in = axis_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_RESETTING;
         count_ff   <= '0;
         exp_len_ff <= '0;
         letter_ff  <= '0;
         axis_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         exp_len_ff <= exp_len_in;
         letter_ff  <= letter_in;
         axis_ff    <= axis_in;
      end
   end

endmodule

// ===== hw/rtl/sapp_datapath.sv =====
// ----------------------------------------------------------------------------
// sapp_datapath
// report nibble shift line, dead zone radius, axis decode and result register
// ----------------------------------------------------------------------------
module sapp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sapp_pkg::cmd_type                 cmd,
   output sapp_pkg::sts_type                 sts,
   input  logic [sapp_pkg::BYTE_W-1:0]       rx_byte,
   input  logic                              csr_wr_en,
   input  logic [sapp_pkg::DZ_W-1:0]         csr_wr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sapp_pkg::EVENT_W-1:0]      rsp_tuser,
   output logic [sapp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int ND = sapp_pkg::NIB_DEPTH;
   localparam int AN = sapp_pkg::AXIS_NIBS;

   logic [ND-1:0][sapp_pkg::NIB_W-1:0]   nib_ff, nib_in;
   logic [sapp_pkg::DZ_W-1:0]            dz_cfg_ff, dz_cfg_in;
   logic [sapp_pkg::DZ_W-1:0]            radius_ff, radius_in;

   logic                                 valid_ff, valid_in;
   logic [sapp_pkg::EVENT_W-1:0]         event_ff, event_in;
   logic [sapp_pkg::INDEX_W-1:0]         index_ff, index_in;
   logic [sapp_pkg::VALUE_W-1:0]         value_ff, value_in;
   logic [sapp_pkg::BTN_W-1:0]           btn_ff, btn_in;
   logic [sapp_pkg::DZ_W-1:0]            dz_ff, dz_in;
   logic                                 last_ff, last_in;

   logic [sapp_pkg::VALUE_W-1:0]         raw;
   logic signed [sapp_pkg::VALUE_W:0]    val_ext;
   logic signed [sapp_pkg::VALUE_W:0]    rad_ext;
   logic                                 in_zone;
   logic [sapp_pkg::VALUE_W-1:0]         axis_val;
   logic [sapp_pkg::BTN_W-1:0]           btn_val;

   // status toward the controller
   assign sts.out_free  = !valid_ff || rsp_tready;
   assign sts.mouse_bit = nib_ff[0][3];

   // nibble shift line: new data nibble in, or one axis word out
   always_comb begin
      nib_in = nib_ff;
      if (cmd.shift_in) begin
         nib_in = {nib_ff[ND-2:0], rx_byte[sapp_pkg::NIB_W-1:0]};
      end else if (cmd.axis_shift) begin
         nib_in = {nib_ff[ND-1-AN:0], {(AN * sapp_pkg::NIB_W){1'b0}}};
      end
   end

   // dead zone radius and its reload value
   always_comb begin
      dz_cfg_in = csr_wr_en ? csr_wr_data : dz_cfg_ff;
      priority if (cmd.load_radius_cfg) begin
         radius_in = dz_cfg_ff;
      end else if (cmd.load_radius_rpt) begin
         radius_in = nib_ff[0];
      end else begin
         radius_in = radius_ff;
      end
   end

   // axis word from the oldest four nibbles, offset and dead zone
   assign raw     = nib_ff[ND-1:ND-AN];
   assign val_ext = $signed({raw[sapp_pkg::VALUE_W-1] ^ 1'b1, raw ^ sapp_pkg::AXIS_OFFSET});
   assign rad_ext = $signed({{(sapp_pkg::VALUE_W + 1 - sapp_pkg::DZ_W){1'b0}}, radius_ff});
   assign in_zone = (val_ext <= rad_ext) && (val_ext >= -rad_ext);
   assign axis_val = in_zone ? '0 : val_ext[sapp_pkg::VALUE_W-1:0];

   // buttons: key 5-8 nibble, key 1-4 nibble, star bit
   assign btn_val = {nib_ff[1], nib_ff[2], nib_ff[0][0]};

   // result register
   always_comb begin
      valid_in = valid_ff;
      event_in = event_ff;
      index_in = index_ff;
      value_in = value_ff;
      btn_in   = btn_ff;
      dz_in    = dz_ff;
      last_in  = last_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
         event_in = cmd.out_event;
         index_in = cmd.out_axis ? cmd.axis_index : '0;
         value_in = cmd.out_axis ? axis_val : '0;
         btn_in   = cmd.out_buttons ? btn_val : '0;
         dz_in    = radius_in;
         last_in  = cmd.out_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dz_cfg_ff <= sapp_pkg::DZ_RESET;
         radius_ff <= sapp_pkg::DZ_RESET;
      end else begin
         valid_ff  <= valid_in;
         dz_cfg_ff <= dz_cfg_in;
         radius_ff <= radius_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      nib_ff   <= nib_in;
      event_ff <= event_in;
      index_ff <= index_in;
      value_ff <= value_in;
      btn_ff   <= btn_in;
      dz_ff    <= dz_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = event_ff;
   assign rsp_tdata  = {dz_ff, btn_ff, value_ff, index_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/six_axis_puck_report_parser.sv =====
// Output: a word that completes a report shows its result on rsp the cycle after it is taken;
// after a 'd' report the sequencer state is registered first, then the axis words load the
// result register in turn, one per cycle while rsp_tready stays high.
// Throughput: one input word per cycle while the result register is free or being drained;
// the axis sequencer holds off input after a 'd' report until its last axis word is loaded.
// Reset: synchronous; the parser waits for a device reset word, dead zone radius
// and its reload register come up as 8, no result pending.
// ----------------------------------------------------------------------------
// six_axis_puck_report_parser
// parses the serial report stream of a six-axis puck into axis, button and status words
// ----------------------------------------------------------------------------
module six_axis_puck_report_parser #(
   parameter int NUM_AXES = sapp_pkg::NUM_AXES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sapp_pkg::BYTE_W-1:0]       req_tdata,   // rx_byte
   input  logic                              req_tuser,   // mode
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sapp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // axis_index, axis_value, buttons, dead_zone
   output logic [sapp_pkg::EVENT_W-1:0]      rsp_tuser,   // event_res
   output logic                              rsp_tlast,   // last
   // dead zone reload register
   input  logic                              csr_wr_en,
   input  logic [sapp_pkg::DZ_W-1:0]         csr_wr_data
);

   sapp_pkg::cmd_type cmd;
   sapp_pkg::sts_type sts;

   // framing and sequencing
   sapp_ctrl #(
      .NUM_AXES (NUM_AXES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .sts        (sts),
      .cmd        (cmd)
   );

   // report storage and result formation
   sapp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .rx_byte     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== hw/rtl/sapp_checker.sv =====
// ----------------------------------------------------------------------------
// sapp_checker
// port-level checks on the puck report parser, bound to the top level
// ----------------------------------------------------------------------------
`include "six_axis_puck_report_parser_defines.svh"

module sapp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [sapp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic [sapp_pkg::EVENT_W-1:0]      rsp_tuser,
   input  logic                              rsp_tlast
);

   logic req_word;
   logic rsp_wait;
   logic not_axis;
   logic not_btn;

   assign req_word = req_tvalid && req_tready;
   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign not_axis = rsp_tvalid && (rsp_tuser != sapp_pkg::EV_AXIS);
   assign not_btn  = rsp_tvalid && (rsp_tuser != sapp_pkg::EV_BUTTONS);

   // stalled response word holds
   `SAPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // axis fields are zero outside axis words
   `SAPP_ASSERT_SAME(a_axis_zero, clock, reset, not_axis, rsp_tdata[18:0] == 19'd0)

   // button field is zero outside button words
   `SAPP_ASSERT_SAME(a_btn_zero, clock, reset, not_btn, rsp_tdata[27:19] == 9'd0)

   // a device reset word never produces a result
   `SAPP_ASSERT_NEXT(a_reset_silent, clock, reset, req_word && (req_tuser == sapp_pkg::MODE_RESET_DONE) && !rsp_tvalid, !rsp_tvalid)

endmodule

bind six_axis_puck_report_parser sapp_checker u_sapp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
